// File: rtl/core/dcc_pkg.sv
// Package for the distinct color counter: sizes and the item carried along the cell chain.
`timescale 1ns / 1ps
package dcc_pkg;

    localparam int ENTRIES     = 128;
    localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W     = $clog2(ENTRIES + 1);
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 4 * CHAN_W;
    localparam int SLOT_OUT_W  = 7;
    localparam int COUNT_OUT_W = 8;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [COLOR_W-1:0] color_t;

    // One item in flight through the chain together with its partial result.
    typedef struct packed {
        logic   vld;
        color_t color;
        logic   clr;
        logic   done;
        logic   is_new;
        slot_t  slot;
        count_t cnt;
    } dcc_item_t;

endpackage

// File: rtl/core/dcc_cell.sv
// One table cell: holds one stored color and processes the item passing by.
`timescale 1ns / 1ps
module dcc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  dcc_pkg::slot_t    idx,
    input  dcc_pkg::dcc_item_t item_in,
    output dcc_pkg::dcc_item_t item_out
);
    import dcc_pkg::*;

    dcc_item_t item_reg;
    dcc_item_t item_next;
    logic      used_reg;
    logic      used_next;
    color_t    color_reg;
    color_t    color_next;
    logic      used_eff;
    logic      match;
    logic      store;

    always_comb
    begin
        // A new set drops this entry before the color is looked at.
        used_eff   = used_reg && !item_in.clr;
        match      = item_in.vld && used_eff && !item_in.done && (color_reg == item_in.color);
        store      = item_in.vld && !used_eff && !item_in.done;
        used_next  = item_in.vld ? (used_eff || store) : used_reg;
        color_next = store ? item_in.color : color_reg;

        item_next        = item_in;
        item_next.done   = item_in.done || match || store;
        item_next.is_new = item_in.is_new || store;
        item_next.slot   = (match || store) ? idx : item_in.slot;
        item_next.cnt    = item_in.cnt + (used_next ? count_t'(1) : count_t'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            item_reg <= '0;
        end
        else if (adv)
        begin
            used_reg <= used_next;
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            color_reg <= color_next;
        end
    end

    assign item_out = item_reg;

endmodule

// File: rtl/core/distinct_color_counter.sv
// Top level of the distinct color counter: a chain of table cells and the result port.
`timescale 1ns / 1ps
// Usage
//   Input channel (color_valid / color_stall): one RGBA color per item plus
//   new_set, which empties the table before the color is handled.
//   Output channel (result_valid / result_stall): one result per item with
//   is_new, slot, distinct_count and overflow, in input order.
//   Each table cell holds one stored color. An item walks the chain one
//   cell per cycle unless the chain holds; at each cell it either hits the
//   stored color, claims the first empty cell, or passes on, and it counts
//   the occupied cells it sees. Items are pipelined behind each other, so
//   one item is taken per cycle while no result is stalled; a later item
//   always sees the cells after the earlier one has passed.
//   A color that finds neither a match nor a free cell leaves with
//   overflow set, slot 0 and distinct_count equal to ENTRIES.
//   Reset empties every cell and drops items in flight.
//   When the receiver stalls a waiting result, the whole chain holds and
//   color_stall is raised until the result is taken.
module distinct_color_counter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           color_valid,
    output logic                           color_stall,
    input  logic [dcc_pkg::CHAN_W-1:0]     red,
    input  logic [dcc_pkg::CHAN_W-1:0]     green,
    input  logic [dcc_pkg::CHAN_W-1:0]     blue,
    input  logic [dcc_pkg::CHAN_W-1:0]     alpha,
    input  logic                           new_set,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           is_new,
    output logic [dcc_pkg::SLOT_OUT_W-1:0] slot,
    output logic [dcc_pkg::COUNT_OUT_W-1:0] distinct_count,
    output logic                           overflow
);
    import dcc_pkg::*;

    dcc_item_t head;
    dcc_item_t chain [ENTRIES];
    dcc_item_t last;
    logic      adv;

    // Advance the whole chain unless a finished result is held by the receiver.
    assign last        = chain[ENTRIES-1];
    assign adv         = !(last.vld && result_stall);
    assign color_stall = !adv;

    // Build the item entering cell 0.
    always_comb
    begin
        head        = '0;
        head.vld    = color_valid;
        head.color  = {red, green, blue, alpha};
        head.clr    = new_set;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            dcc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .idx      (slot_t'(gi)),
                .item_in  ((gi == 0) ? head : chain[(gi == 0) ? 0 : gi - 1]),
                .item_out (chain[gi])
            );
        end
    endgenerate

    // A color that was neither found nor stored means the table was full.
    assign result_valid   = last.vld;
    assign overflow       = !last.done;
    assign is_new         = last.is_new || !last.done;
    assign slot           = last.done ? SLOT_OUT_W'(last.slot) : '0;
    assign distinct_count = COUNT_OUT_W'(last.cnt);

    // Overflow only happens with every cell occupied.
    a_full_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (last.vld && !last.done) |-> (last.cnt == count_t'(ENTRIES)))
        else $error("overflow with free cells");

    // Input is held back only by a waiting, stalled result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        color_stall |-> (result_valid && result_stall))
        else $error("input stalled without output backpressure");

    // A color that was already stored implies a nonempty table.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (last.vld && !last.is_new) |-> (last.cnt != '0))
        else $error("hit reported on an empty table");

    // A result that is stalled stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(last)))
        else $error("stalled result changed");

endmodule

// File: sim/color_tally_checker.sv
// Checker for the distinct color counter: mirrors the color table and compares every result.
`timescale 1ns / 1ps
module color_tally_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            color_valid,
    input  logic                            color_stall,
    input  logic [dcc_pkg::CHAN_W-1:0]      red,
    input  logic [dcc_pkg::CHAN_W-1:0]      green,
    input  logic [dcc_pkg::CHAN_W-1:0]      blue,
    input  logic [dcc_pkg::CHAN_W-1:0]      alpha,
    input  logic                            new_set,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic                            is_new,
    input  logic [dcc_pkg::SLOT_OUT_W-1:0]  slot,
    input  logic [dcc_pkg::COUNT_OUT_W-1:0] distinct_count,
    input  logic                            overflow,
    output int                              failures,
    output int                              pending
);
    import dcc_pkg::*;

    typedef struct {
        logic                   is_new;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [COUNT_OUT_W-1:0] distinct_count;
        logic                   overflow;
    } tally_t;

    color_t seen_colors [ENTRIES];
    int     seen_count;
    tally_t tally_q [$];
    tally_t want;

    // Look the color up among the stored ones, append it if new and room is left.
    function automatic tally_t tally_color(input color_t color, input logic clear);
        tally_t t;
        int     hit;
        bit     found;
        if (clear)
            seen_count = 0;
        found = 0;
        hit   = 0;
        for (int i = 0; i < seen_count; i++)
        begin
            if (!found && seen_colors[i] == color)
            begin
                found = 1;
                hit   = i;
            end
        end
        t.is_new   = !found;
        t.overflow = 1'b0;
        if (!found)
        begin
            if (seen_count < ENTRIES)
            begin
                hit              = seen_count;
                seen_colors[hit] = color;
                seen_count++;
            end
            else
            begin
                t.overflow = 1'b1;
                hit        = 0;
            end
        end
        t.slot           = hit[SLOT_OUT_W-1:0];
        t.distinct_count = seen_count[COUNT_OUT_W-1:0];
        return t;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        failures++;
        $display("[%0t] result mismatch on %s: expected %0h, got %0h",
                 $time, field, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_count = 0;
            tally_q.delete();
            pending <= 0;
        end
        else
        begin
            // Retire first, so a result can never match the item taken at the same edge.
            if (result_valid && !result_stall)
            begin
                if (tally_q.size() == 0)
                    report_mismatch("unexpected result", 32'h0, 32'h1);
                else
                begin
                    want = tally_q.pop_front();
                    if (is_new !== want.is_new)
                        report_mismatch("is_new", 32'(want.is_new), 32'(is_new));
                    if (slot !== want.slot)
                        report_mismatch("slot", 32'(want.slot), 32'(slot));
                    if (distinct_count !== want.distinct_count)
                        report_mismatch("distinct_count", 32'(want.distinct_count),
                                        32'(distinct_count));
                    if (overflow !== want.overflow)
                        report_mismatch("overflow", 32'(want.overflow), 32'(overflow));
                end
            end
            if (color_valid && !color_stall)
                tally_q.push_back(tally_color({red, green, blue, alpha}, new_set));
            pending <= tally_q.size();
        end
    end

endmodule

// File: sim/distinct_color_counter_tb.sv
// Testbench top for the distinct color counter: drives colors, stalls results, gives the verdict.
`timescale 1ns / 1ps
module distinct_color_counter_tb;

    import dcc_pkg::*;

    // The chain is ENTRIES cells long, so a result trails its item through
    // every cell; DRAIN_CYCLES leaves a margin past that before calling the block quiet.
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
    // Watchdog limit, far above what a correct run needs even at the heaviest stall mix.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 550;
    localparam int PALETTE_MAX  = 12;
    localparam int N_DIRECTED   = 18;

    // Directed colors: extremes, one-channel and one-bit neighbors, repeats,
    // and new sets that reopen a color already in the table.
    localparam color_t DIRECTED_COLORS [N_DIRECTED] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0100_0000, 32'h0001_0000, 32'h0000_0100, 32'h0000_0001,
        32'h8000_0000, 32'h0000_0080, 32'h0100_0000, 32'hFFFF_FFFE,
        32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h7F80_01FE, 32'h7F80_01FE
    };
    localparam logic [N_DIRECTED-1:0] DIRECTED_NEW_SET = 18'b00_0101_0000_0000_0001;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   color_valid = 1'b0;
    logic                   color_stall;
    logic [CHAN_W-1:0]      red = '0;
    logic [CHAN_W-1:0]      green = '0;
    logic [CHAN_W-1:0]      blue = '0;
    logic [CHAN_W-1:0]      alpha = '0;
    logic                   new_set = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   is_new;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [COUNT_OUT_W-1:0] distinct_count;
    logic                   overflow;

    int     mismatch_count;
    int     outstanding;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     items_sent = 0;
    int     sets_run = 0;
    int     phase_goal;
    int     palette_size;
    int     set_len;
    color_t palette [PALETTE_MAX];
    color_t fill_colors [ENTRIES];

    always #5 clk = ~clk;

    distinct_color_counter DUT (.*);

    color_tally_checker tally_chk (
        .*,
        .failures (mismatch_count),
        .pending  (outstanding)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("distinct_color_counter_tb NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure: stall at random with the current mix, never in reset.
    always @(posedge clk)
        result_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // Offer one color, with random idle cycles ahead of it, and hold it until taken.
    // The stall seen right after the edge is the one that decided acceptance.
    task automatic send_color(input color_t c, input logic clear);
        while ($urandom_range(99) < send_idle_pct)
        begin
            color_valid <= 1'b0;
            @(posedge clk);
        end
        color_valid <= 1'b1;
        red         <= c[31:24];
        green       <= c[23:16];
        blue        <= c[15:8];
        alpha       <= c[7:0];
        new_set     <= clear;
        do
            @(posedge clk);
        while (color_stall);
        items_sent++;
    endtask

    // Drop valid and hold off until every outstanding result is back.
    // Skip one edge first so the count includes the item just taken.
    task automatic wait_drained();
        color_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // Hold reset low from the start, then release it on a clock edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs under the first stall mix.
        send_idle_pct = 32;
        stall_pct     = 67;
        for (int d = 0; d < N_DIRECTED; d++)
            send_color(DIRECTED_COLORS[d], DIRECTED_NEW_SET[d]);

        // Random part in three phases: sender slow / receiver slower, then the
        // reverse, then full speed on both sides. Every phase opens with the
        // sender paused until the block has returned everything.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 32;
                    stall_pct     = 67;
                end
                1:
                begin
                    send_idle_pct = 67;
                    stall_pct     = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            wait_drained();
            phase_goal = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < phase_goal)
            begin
                if (phase == 1 && items_sent < phase_goal - RANDOM_ITEMS / 3 + 1)
                begin
                    // Fill the table: ENTRIES colors kept apart by their red
                    // channel, then new colors past capacity, then hits that
                    // reach the top slot while the table is full.
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        fill_colors[i] = {i[7:0], 24'($urandom)};
                        send_color(fill_colors[i], i == 0);
                    end
                    for (int k = 0; k < 6; k++)
                        send_color({8'(ENTRIES + k), 24'($urandom)}, 1'b0);
                    send_color(fill_colors[ENTRIES-1], 1'b0);
                    for (int k = 0; k < 7; k++)
                        send_color(fill_colors[$urandom_range(ENTRIES-1)], 1'b0);
                end
                else
                begin
                    // A set drawn from a small palette so colors repeat; some
                    // palette entries sit one bit away from their neighbor.
                    palette_size = $urandom_range(1, PALETTE_MAX);
                    for (int j = 0; j < palette_size; j++)
                    begin
                        if (j > 0 && $urandom_range(3) == 0)
                            palette[j] = palette[j-1] ^ (32'h1 << $urandom_range(31));
                        else
                            palette[j] = $urandom;
                    end
                    set_len = $urandom_range(4, 40);
                    for (int n = 0; n < set_len; n++)
                    begin
                        // Mostly a clean set start; now and then carry the old
                        // table on, or break the set with a stray clear.
                        if ($urandom_range(9) == 0)
                            send_color($urandom,
                                       n == 0 ? $urandom_range(7) != 0 : $urandom_range(39) == 0);
                        else
                            send_color(palette[$urandom_range(palette_size-1)],
                                       n == 0 ? $urandom_range(7) != 0 : $urandom_range(39) == 0);
                    end
                end
                sets_run++;
            end
        end

        // Let the chain empty, then watch a while longer for stray results.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d colors in %0d random sets plus a directed group,", items_sent, sets_run);
        $display("including one table filled past capacity, under three stall mixes.");
        if (mismatch_count == 0)
            $display("distinct_color_counter_tb OK");
        else
            $display("distinct_color_counter_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/dcc_pkg.sv
rtl/core/dcc_cell.sv
rtl/core/distinct_color_counter.sv
sim/color_tally_checker.sv
sim/distinct_color_counter_tb.sv
